@@ hw/rtl/pst_pkg.sv @@
package pst_pkg;

    // table size and thread limit
    localparam int SLOT_COUNT   = 256;
    localparam int THREAD_LIMIT = 16;

    // field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 9;
    localparam int PRIO_W = 8;
    localparam int TH_W   = 5;
    localparam int STAT_W = 3;

    // slot index width and a width that holds any id or slot count
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CALC_W = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;

    // thread counter tops out at the thread limit, or at its widest value if that is smaller
    localparam int THREAD_TOP   = (2 ** TH_W) - 1;
    localparam int THREAD_CAP_I = (THREAD_LIMIT > THREAD_TOP) ? THREAD_TOP : THREAD_LIMIT;
    localparam logic [TH_W-1:0] THREAD_CAP = TH_W'(THREAD_CAP_I);

    // opcodes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_KILL    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
    localparam logic [STAT_W-1:0] STAT_LIMIT   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NONE    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   process_id;
        logic [ID_W-1:0]   parent_id;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   assigned_id;
        logic [TH_W-1:0]   thread_count;
    } rsp_t;

    // one table entry as held in the ram
    typedef struct packed {
        logic [ID_W-1:0]   parent;
        logic [PRIO_W-1:0] prio;
        logic              blocked;
        logic [TH_W-1:0]   threads;
    } entry_t;

endpackage

@@ hw/rtl/pst_ram.sv @@
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/process_slot_table.sv @@
// Process slot table. Commands (create, kill, suspend, resume, add thread,
// remove thread) arrive one item at a time on the cmd channel and each gives
// exactly one item on the rsp channel. A command runs in two states. In the
// cycle it is accepted the target entry is read from the entry ram and, for
// create, the lowest group of 32 slots with a free slot is picked from the
// used bits; then in S_EXEC the entry is modified and, if the command
// changes it, written back, the lowest free slot in that group is chosen,
// and the result is loaded into the output register. S_EXEC waits while
// rsp_stall holds an earlier result there, and no new command is taken until
// the result is loaded. The used bits live in flip-flops cleared at reset,
// so the block is ready right after reset with no clearing pass. Parent,
// priority, blocked and thread count sit in a ram, and their values are only
// ever used for slots that create has written.
module process_slot_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pst_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pst_pkg::rsp_t rsp
);
    import pst_pkg::*;

    // free-slot search works on groups of 32 slots
    localparam int GROUP_W = 32;
    localparam int BIT_W   = 5;
    localparam int GROUPS  = (SLOT_COUNT + GROUP_W - 1) / GROUP_W;
    localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAD_W   = GROUPS * GROUP_W;
    localparam int ENT_W   = $bits(entry_t);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                  state_reg, state_next;
    logic [SLOT_COUNT-1:0]   used_reg, used_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [SLOT_W-1:0]       tgt_reg, tgt_next;
    logic                    tgt_ok_reg, tgt_ok_next;
    logic [GRP_W-1:0]        grp_reg, grp_next;
    logic                    full_reg, full_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    // used bits padded to whole groups; slots past the end look used
    logic [PAD_W-1:0]        pad_used;

    // accept-side decode
    logic                    cmd_fire;
    logic [CALC_W-1:0]       pid_ext;
    logic [CALC_W-1:0]       pid_slot;
    logic [SLOT_W-1:0]       tgt;
    logic [GRP_W-1:0]        grp_sel;
    logic                    any_free;

    // execute-side
    logic [GROUP_W-1:0]      grp_bits;
    logic [BIT_W-1:0]        bit_sel;
    logic [CALC_W-1:0]       new_ext;
    logic [SLOT_W-1:0]       new_slot;
    logic [ID_W-1:0]         new_id;
    entry_t                  entry_rd;
    entry_t                  entry_wr;
    logic [ENT_W-1:0]        rd_data;
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;

    for (genvar i = 0; i < PAD_W; i++)
    begin : g_pad
        if (i < SLOT_COUNT)
        begin : g_real
            assign pad_used[i] = used_reg[i];
        end
        else
        begin : g_fill
            assign pad_used[i] = 1'b1;
        end
    end

    assign cmd_fire  = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);

    // target slot is id minus one
    assign pid_ext  = CALC_W'(cmd.process_id);
    assign pid_slot = pid_ext - CALC_W'(1);
    assign tgt      = pid_slot[SLOT_W-1:0];

    // lowest group holding a free slot
    always_comb
    begin
        grp_sel  = '0;
        any_free = 1'b0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (!(&pad_used[g*GROUP_W +: GROUP_W]))
            begin
                grp_sel  = GRP_W'(g);
                any_free = 1'b1;
            end
        end
    end

    // lowest free slot inside the chosen group
    assign grp_bits = pad_used[int'(grp_reg) * GROUP_W +: GROUP_W];

    always_comb
    begin
        bit_sel = '0;
        for (int b = GROUP_W - 1; b >= 0; b--)
        begin
            if (!grp_bits[b])
            begin
                bit_sel = BIT_W'(b);
            end
        end
    end

    assign new_ext  = CALC_W'({grp_reg, bit_sel});
    assign new_slot = new_ext[SLOT_W-1:0];
    assign new_id   = ID_W'(new_ext + CALC_W'(1));

    assign entry_rd = entry_t'(rd_data);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        cmd_next       = cmd_reg;
        tgt_next       = tgt_reg;
        tgt_ok_next    = tgt_ok_reg;
        grp_next       = grp_reg;
        full_next      = full_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = tgt_reg;
        entry_wr       = entry_rd;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    tgt_next    = tgt;
                    tgt_ok_next = (cmd.process_id != '0)
                                  && (pid_ext <= CALC_W'(SLOT_COUNT))
                                  && used_reg[tgt]
                                  && (cmd.opcode <= OP_REMOVE);
                    grp_next    = grp_sel;
                    full_next   = !any_free;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait while the previous result is still held
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    rsp_next       = '{status: STAT_INVALID, assigned_id: '0, thread_count: '0};
                    if (cmd_reg.opcode == OP_CREATE)
                    begin
                        if (full_reg)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            entry_wr = '{parent: cmd_reg.parent_id, prio: cmd_reg.priority_req,
                                         blocked: 1'b0, threads: '0};
                            ram_we              = 1'b1;
                            ram_waddr           = new_slot;
                            used_next[new_slot] = 1'b1;
                            rsp_next.status      = STAT_OK;
                            rsp_next.assigned_id = new_id;
                        end
                    end
                    else if (tgt_ok_reg)
                    begin
                        rsp_next.status       = STAT_OK;
                        rsp_next.assigned_id  = cmd_reg.process_id;
                        rsp_next.thread_count = entry_rd.threads;
                        case (cmd_reg.opcode)
                            OP_KILL:
                            begin
                                entry_wr.threads      = '0;
                                ram_we                = 1'b1;
                                used_next[tgt_reg]    = 1'b0;
                                rsp_next.thread_count = '0;
                            end
                            OP_SUSPEND:
                            begin
                                entry_wr.blocked = 1'b1;
                                ram_we           = 1'b1;
                            end
                            OP_RESUME:
                            begin
                                entry_wr.blocked = 1'b0;
                                ram_we           = 1'b1;
                            end
                            OP_ADD:
                            begin
                                if (entry_rd.threads >= THREAD_CAP)
                                begin
                                    rsp_next.status      = STAT_LIMIT;
                                    rsp_next.assigned_id = '0;
                                end
                                else
                                begin
                                    entry_wr.threads      = entry_rd.threads + TH_W'(1);
                                    ram_we                = 1'b1;
                                    rsp_next.thread_count = entry_rd.threads + TH_W'(1);
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (entry_rd.threads == '0)
                                begin
                                    rsp_next.status      = STAT_NONE;
                                    rsp_next.assigned_id = '0;
                                end
                                else
                                begin
                                    entry_wr.threads      = entry_rd.threads - TH_W'(1);
                                    ram_we                = 1'b1;
                                    rsp_next.thread_count = entry_rd.threads - TH_W'(1);
                                end
                            end
                            default:
                            begin
                                rsp_next = '{status: STAT_INVALID, assigned_id: '0,
                                             thread_count: '0};
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cmd_reg       <= '0;
            tgt_reg       <= '0;
            tgt_ok_reg    <= 1'b0;
            grp_reg       <= '0;
            full_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmd_reg       <= cmd_next;
            tgt_reg       <= tgt_next;
            tgt_ok_reg    <= tgt_ok_next;
            grp_reg       <= grp_next;
            full_reg      <= full_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // entry ram: read on accept, written back in S_EXEC
    pst_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (entry_wr),
        .re    (cmd_fire),
        .raddr (tgt),
        .rdata (rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // one command at a time: busy in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command accepted while another was in flight");

    // failures never report an id
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_OK) |-> (rsp.assigned_id == '0))
        else $error("failed command reported an id");

    // success always reports a nonzero id
    a_ok_has_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_OK) |-> (rsp.assigned_id != '0))
        else $error("successful command reported id zero");

    // thread count never passes the limit
    a_thread_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.thread_count <= THREAD_CAP))
        else $error("thread count above limit");

endmodule

@@ dv/process_slot_table_checker.sv @@
`timescale 1ns / 100ps

module process_slot_table_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  pst_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  pst_pkg::rsp_t rsp,
    output int            mismatch_count,
    output int            outstanding
);
    import pst_pkg::*;

    localparam int COUNT_TOP = (1 << TH_W) - 1;
    localparam int COUNT_CAP = (THREAD_LIMIT < COUNT_TOP) ? THREAD_LIMIT : COUNT_TOP;

    // shadow copy of the slot table
    logic              used_q    [SLOT_COUNT];
    logic [ID_W-1:0]   parent_q  [SLOT_COUNT];
    logic [PRIO_W-1:0] prio_q    [SLOT_COUNT];
    logic              blocked_q [SLOT_COUNT];
    logic [TH_W-1:0]   threads_q [SLOT_COUNT];

    rsp_t expected_rsp [$];
    int   errs = 0;

    // applies one command to the shadow table and gives the response it earns
    function automatic rsp_t slot_table_outcome(input cmd_t c);
        rsp_t r;
        int   slot;
        int   pid;
        r        = '0;
        r.status = STAT_INVALID;
        pid      = int'(c.process_id);
        if (c.opcode == OP_CREATE) begin
            r.status = STAT_FULL;
            slot     = -1;
            for (int s = SLOT_COUNT - 1; s >= 0; s--)
                if (!used_q[s])
                    slot = s;
            if (slot >= 0) begin
                used_q[slot]    = 1'b1;
                parent_q[slot]  = c.parent_id;
                prio_q[slot]    = c.priority_req;
                blocked_q[slot] = 1'b0;
                threads_q[slot] = '0;
                r.status        = STAT_OK;
                r.assigned_id   = ID_W'(slot + 1);
            end
        end else if (c.opcode <= OP_REMOVE && pid >= 1 && pid <= SLOT_COUNT &&
                     used_q[pid - 1]) begin
            slot          = pid - 1;
            r.status      = STAT_OK;
            r.assigned_id = c.process_id;
            case (c.opcode)
                OP_KILL:
                begin
                    used_q[slot]    = 1'b0;
                    threads_q[slot] = '0;
                end
                OP_SUSPEND:
                begin
                    blocked_q[slot] = 1'b1;
                    r.thread_count  = threads_q[slot];
                end
                OP_RESUME:
                begin
                    blocked_q[slot] = 1'b0;
                    r.thread_count  = threads_q[slot];
                end
                OP_ADD:
                begin
                    if (int'(threads_q[slot]) >= COUNT_CAP) begin
                        r.status      = STAT_LIMIT;
                        r.assigned_id = '0;
                    end else begin
                        threads_q[slot] = threads_q[slot] + 1'b1;
                    end
                    r.thread_count = threads_q[slot];
                end
                default:
                begin
                    if (threads_q[slot] == '0) begin
                        r.status      = STAT_NONE;
                        r.assigned_id = '0;
                    end else begin
                        threads_q[slot] = threads_q[slot] - 1'b1;
                        r.thread_count  = threads_q[slot];
                    end
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        rsp_t want;
        if (!rst_n) begin
            for (int s = 0; s < SLOT_COUNT; s++)
                used_q[s] = 1'b0;
            expected_rsp.delete();
        end else begin
            if (cmd_valid && !cmd_stall)
                expected_rsp.push_back(slot_table_outcome(cmd));
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %p", $time, rsp);
                    errs++;
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp.status);
                        errs++;
                    end
                    if (rsp.assigned_id !== want.assigned_id) begin
                        $display("%0t: assigned_id expected %0d got %0d",
                                 $time, want.assigned_id, rsp.assigned_id);
                        errs++;
                    end
                    if (rsp.thread_count !== want.thread_count) begin
                        $display("%0t: thread_count expected %0d got %0d",
                                 $time, want.thread_count, rsp.thread_count);
                        errs++;
                    end
                end
            end
        end
        mismatch_count <= errs;
        outstanding    <= expected_rsp.size();
    end

endmodule

@@ dv/process_slot_table_test.sv @@
`timescale 1ns / 100ps

module process_slot_table_test;
    import pst_pkg::*;

    // cycles with no item moving on either channel before the run is declared hung
    localparam int IDLE_LIMIT   = 4000;
    // random stimulus length
    localparam int RANDOM_ITEMS = 1450;
    localparam int ID_MAX       = (1 << ID_W) - 1;
    localparam int PRIO_MAX     = (1 << PRIO_W) - 1;
    // opcodes the block does not define, both must answer invalid
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_BEAT} stall_mode_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int mismatch_count;
    int outstanding;

    // occupancy as the stimulus sees it, so most commands land on live slots
    bit live [SLOT_COUNT];

    int burst_left  = 0;
    int idle_cycles = 0;
    int sent        = 0;

    process_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // watches both channels, predicts every response and counts mismatches
    process_slot_table_checker slot_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd            (cmd),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver back-pressure: the pattern switches at random between
    // no stall, coin flips, short solid runs and a fixed beat
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          stall_run  = 0;
    int          beat       = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            beat = (beat + 1) % 3;
            case (stall_mode)
                STALL_NONE:
                    rsp_stall <= 1'b0;
                STALL_COIN:
                    rsp_stall <= 1'($urandom_range(0, 1));
                STALL_RUNS:
                begin
                    if (stall_run == 0 && $urandom_range(0, 5) == 0)
                        stall_run = $urandom_range(1, 8);
                    rsp_stall <= (stall_run > 0);
                    if (stall_run > 0)
                        stall_run--;
                end
                default:
                    rsp_stall <= (beat == 0);
            endcase
        end
    end

    // hang detection: any accepted item on either side restarts the count
    always @(posedge clk) begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic bit table_full();
        for (int s = 0; s < SLOT_COUNT; s++)
            if (!live[s])
                return 1'b0;
        return 1'b1;
    endfunction

    // a live id from a random starting point, or any legal id when none is live
    function automatic int pick_live();
        int start;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++)
            if (live[(start + k) % SLOT_COUNT])
                return (start + k) % SLOT_COUNT + 1;
        return start + 1;
    endfunction

    // drives one item and waits for its acceptance; items go out in bursts with
    // idle gaps between them, so valid is never dropped and raised in
    // the same step
    task automatic send_item(input logic [OP_W-1:0] op, input int pid, input int parent,
                             input int prio);
        cmd_t c;
        int   gap;
        c.opcode       = op;
        c.process_id   = ID_W'(pid);
        c.parent_id    = ID_W'(parent);
        c.priority_req = PRIO_W'(prio);
        if (burst_left == 0) begin
            gap       = $urandom_range(1, 8);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        burst_left--;
        sent++;
        // keep the occupancy view in step: create takes the lowest free slot
        if (op == OP_CREATE) begin
            for (int s = 0; s < SLOT_COUNT; s++)
                if (!live[s]) begin
                    live[s] = 1'b1;
                    break;
                end
        end else if (op == OP_KILL && pid >= 1 && pid <= SLOT_COUNT) begin
            live[pid - 1] = 1'b0;
        end
    endtask

    // stops sending and waits until every response has come back
    task automatic drain();
        cmd_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic create_random();
        send_item(OP_CREATE, $urandom_range(0, ID_MAX), $urandom_range(0, ID_MAX),
                  $urandom_range(0, PRIO_MAX));
    endtask

    // kill, suspend, resume, add or remove, mostly on a live slot
    task automatic slot_op_random();
        int target;
        target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, SLOT_COUNT) : pick_live();
        send_item(OP_OP_PICK(), target, $urandom_range(0, ID_MAX),
                  $urandom_range(0, PRIO_MAX));
    endtask

    function automatic logic [OP_W-1:0] OP_OP_PICK();
        return OP_W'($urandom_range(int'(OP_KILL), int'(OP_REMOVE)));
    endfunction

    // tries to drive one slot's thread count past the limit and then below zero
    task automatic thread_ramp(input int target);
        repeat (THREAD_CAP_I + 2)
            send_item(OP_ADD, target, $urandom_range(0, ID_MAX), $urandom_range(0, PRIO_MAX));
        repeat (THREAD_CAP_I + 2)
            send_item(OP_REMOVE, target, $urandom_range(0, ID_MAX),
                      $urandom_range(0, PRIO_MAX));
    endtask

    initial
    begin
        int pick;
        int target;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every opcode, the error paths
        send_item(OP_CREATE, 0, 0, 0);
        send_item(OP_CREATE, ID_MAX, ID_MAX, PRIO_MAX);  // process_id ignored on create
        send_item(OP_CREATE, 0, 256, 128);
        send_item(OP_SUSPEND, 1, 0, 0);
        send_item(OP_RESUME, 1, 0, 0);
        send_item(OP_ADD, 2, 0, 0);
        send_item(OP_ADD, 2, 0, 0);
        send_item(OP_REMOVE, 2, 0, 0);
        send_item(OP_REMOVE, 2, 0, 0);
        send_item(OP_REMOVE, 2, 0, 0);                   // no threads left
        send_item(OP_KILL, 3, 0, 0);
        send_item(OP_SUSPEND, 3, 0, 0);                  // target slot is free
        send_item(OP_ADD, 0, 0, 0);                      // id zero
        send_item(OP_RESUME, SLOT_COUNT + 1, 0, 0);      // just past the table
        send_item(OP_KILL, ID_MAX, ID_MAX, PRIO_MAX);    // widest id
        send_item(OP_SUSPEND, SLOT_COUNT, 0, 0);         // top id, still free
        send_item(OP_SPARE_LO, 1, 0, 0);
        send_item(OP_SPARE_HI, ID_MAX, ID_MAX, PRIO_MAX);
        send_item(OP_CREATE, 0, 5, 7);                   // reuses slot 3
        send_item(OP_KILL, 1, 0, 0);
        send_item(OP_CREATE, ID_MAX, 0, PRIO_MAX);       // back into slot 1

        // let everything settle once before the random part
        drain();
        sent = 0;

        // fill the table, with some traffic mixed in, then push past full
        while (!table_full()) begin
            if ($urandom_range(0, 4) == 0)
                slot_op_random();
            else
                create_random();
        end
        repeat (3) create_random();
        thread_ramp(SLOT_COUNT);

        // mixed traffic
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 40)) create_random();
            end else if (pick < 16) begin
                thread_ramp(pick_live());
            end else if (pick < 26) begin
                repeat ($urandom_range(1, 20)) begin
                    target = pick_live();
                    send_item(OP_KILL, target, $urandom_range(0, ID_MAX),
                              $urandom_range(0, PRIO_MAX));
                end
            end else if (pick < 84) begin
                slot_op_random();
            end else if (pick == 99) begin
                drain();
            end else begin
                // noise: any opcode, any id
                send_item(OP_W'($urandom_range(0, 7)), $urandom_range(0, ID_MAX),
                          $urandom_range(0, ID_MAX), $urandom_range(0, PRIO_MAX));
            end
        end

        // wait out the last responses, then idle on for anything stray
        drain();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
